// File: rtl/kscl_pkg.sv
package kscl_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MS_W    = 6;
  localparam int unsigned TICK_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_KEY   = 2'd0,
    CMD_PULSE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } kscl_cmd_t;

  typedef enum logic [1:0] {
    EDIT_NONE = 2'd0,
    EDIT_SEC  = 2'd1,
    EDIT_MIN  = 2'd2,
    EDIT_HOUR = 2'd3
  } kscl_edit_t;

  localparam logic [KEY_W-1:0] KEY_LAST_DIGIT = 4'd9;
  localparam logic [KEY_W-1:0] KEY_MODE       = 4'hC;
  localparam logic [KEY_W-1:0] KEY_DIR        = 4'hD;
  localparam logic [KEY_W-1:0] KEY_EDIT       = 4'hE;

  localparam logic [COUNT_W-1:0] MAX_LIMIT = 7'd99;
  localparam logic [HOUR_W-1:0]  MAX_HOUR  = 5'd23;
  localparam logic [MS_W-1:0]    MAX_MS    = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_TENS_CAP = 5'd20;
  localparam logic [MS_W-1:0]    MS_TENS_CAP   = 6'd50;
  localparam logic [TICK_W-1:0]  TPS_RESET     = 8'd10;

  typedef struct packed {
    logic [COUNT_W-1:0] counter;
    logic [COUNT_W-1:0] limit;
    logic               down;
    logic               enable;
    logic               mode;
    kscl_edit_t         edit_sel;
    logic               digit;
    logic [HOUR_W-1:0]  hour;
    logic [MS_W-1:0]    minute;
    logic [MS_W-1:0]    second;
    logic [TICK_W-1:0]  tick_count;
  } kscl_state_t;

endpackage

// File: rtl/kscl_in_if.sv
interface kscl_in_if import kscl_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] key_code;

  modport source (output valid, output command, output key_code, input ready);
  modport sink   (input valid, input command, input key_code, output ready);
endinterface

// File: rtl/kscl_out_if.sv
interface kscl_out_if import kscl_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count_value;
  logic [COUNT_W-1:0] count_limit;
  logic               count_down;
  logic               count_enabled;
  logic               clock_mode;
  logic [1:0]         edit_field;
  logic               second_digit_next;
  logic [HOUR_W-1:0]  hours;
  logic [MS_W-1:0]    minutes;
  logic [MS_W-1:0]    seconds;

  modport source (
    output valid, output count_value, output count_limit, output count_down,
    output count_enabled, output clock_mode, output edit_field,
    output second_digit_next, output hours, output minutes, output seconds,
    input ready
  );
  modport sink (
    input valid, input count_value, input count_limit, input count_down,
    input count_enabled, input clock_mode, input edit_field,
    input second_digit_next, input hours, input minutes, input seconds,
    output ready
  );
endinterface

// File: rtl/kscl_next.sv
module kscl_next import kscl_pkg::*; (
  input  kscl_state_t       cur,
  input  kscl_cmd_t         cmd,
  input  logic [KEY_W-1:0]  key,
  input  logic [TICK_W-1:0] tps,
  output kscl_state_t       nxt
);

  logic [COUNT_W-1:0] limit_tens;
  logic [COUNT_W:0]   limit_sum;
  logic [COUNT_W-1:0] limit_units;
  logic [HOUR_W-1:0]  hour_tens;
  logic [HOUR_W:0]    hour_sum;
  logic [HOUR_W-1:0]  hour_units;
  logic [MS_W-1:0]    ms_tens;
  logic [MS_W:0]      min_sum;
  logic [MS_W:0]      sec_sum;
  logic [COUNT_W:0]   count_inc;
  logic [TICK_W:0]    tick_inc;

  always_comb begin
    limit_tens  = 7'(key) * 7'd10;
    limit_sum   = 8'(cur.limit) + 8'(key);
    limit_units = (limit_sum > 8'(MAX_LIMIT)) ? MAX_LIMIT : limit_sum[COUNT_W-1:0];

    hour_tens = (key > 4'd2) ? HOUR_TENS_CAP : 5'(key) * 5'd10;
    hour_sum  = 6'(cur.hour) + 6'(key);
    if (cur.hour == HOUR_TENS_CAP && key > 4'd3) begin
      hour_units = MAX_HOUR;
    end else if (hour_sum > 6'(MAX_HOUR)) begin
      hour_units = MAX_HOUR;
    end else begin
      hour_units = hour_sum[HOUR_W-1:0];
    end

    ms_tens = (key > 4'd5) ? MS_TENS_CAP : 6'(key) * 6'd10;
    min_sum = 7'(cur.minute) + 7'(key);
    sec_sum = 7'(cur.second) + 7'(key);

    count_inc = 8'(cur.counter) + 8'd1;
    tick_inc  = 9'(cur.tick_count) + 9'd1;
  end

  always_comb begin
    nxt = cur;
    case (cmd)
      CMD_KEY: begin
        if (key <= KEY_LAST_DIGIT) begin
          nxt.digit = ~cur.digit;
          if (!cur.digit) begin
            if (!cur.mode) begin
              nxt.limit  = limit_tens;
              nxt.enable = 1'b0;
            end else begin
              case (cur.edit_sel)
                EDIT_HOUR: nxt.hour   = hour_tens;
                EDIT_MIN:  nxt.minute = ms_tens;
                EDIT_SEC:  nxt.second = ms_tens;
                default:   ;
              endcase
            end
          end else begin
            if (!cur.mode) begin
              nxt.limit   = limit_units;
              nxt.counter = cur.down ? limit_units : '0;
              nxt.enable  = 1'b1;
            end else begin
              case (cur.edit_sel)
                EDIT_HOUR: nxt.hour = hour_units;
                EDIT_MIN: begin
                  nxt.minute = (min_sum > 7'(MAX_MS)) ? MAX_MS : min_sum[MS_W-1:0];
                end
                EDIT_SEC: begin
                  nxt.second = (sec_sum > 7'(MAX_MS)) ? MAX_MS : sec_sum[MS_W-1:0];
                end
                default: ;
              endcase
            end
          end
        end else if (key == KEY_DIR) begin
          if (!cur.mode) nxt.down = ~cur.down;
        end else if (key == KEY_MODE) begin
          nxt.mode = ~cur.mode;
        end else if (key == KEY_EDIT) begin
          // The selector steps downwards: none, hours, minutes, seconds.
          if (cur.mode) nxt.edit_sel = kscl_edit_t'(cur.edit_sel - 2'd1);
        end
      end
      CMD_PULSE: begin
        if (cur.enable) begin
          if (!cur.down) begin
            nxt.counter = (count_inc > 8'(cur.limit)) ? 7'd1 : count_inc[COUNT_W-1:0];
          end else if (cur.counter == '0) begin
            nxt.counter = (cur.limit == '0) ? '0 : cur.limit - 7'd1;
          end else begin
            nxt.counter = cur.counter - 7'd1;
          end
        end
      end
      CMD_TICK: begin
        // The clock is frozen while any field is being edited.
        if (cur.edit_sel == EDIT_NONE) begin
          if (tick_inc >= 9'(tps)) begin
            nxt.tick_count = '0;
            if (cur.second >= MAX_MS) begin
              nxt.second = '0;
              if (cur.minute >= MAX_MS) begin
                nxt.minute = '0;
                nxt.hour   = (cur.hour >= MAX_HOUR) ? '0 : cur.hour + 5'd1;
              end else begin
                nxt.minute = cur.minute + 6'd1;
              end
            end else begin
              nxt.second = cur.second + 6'd1;
            end
          end else begin
            nxt.tick_count = tick_inc[TICK_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/keypad_set_clock_and_limit_counter.sv
// A word accepted into the input register gives its result in the state register.
// Throughput: one word per cycle while out_ch.ready does not stall the output;
// the input register and the result register each hold one word.
// Reset (rst_n low, synchronous) clears all state, empties both registers and
// sets ticks_per_second to 10.
module keypad_set_clock_and_limit_counter import kscl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  kscl_in_if.sink           in_ch,
  kscl_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [TICK_W-1:0] cfg_wr_data
);

  logic              s1_valid_r;
  kscl_cmd_t         s1_cmd_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [TICK_W-1:0] tps_r;
  kscl_state_t       state_r;
  kscl_state_t       state_nxt;
  logic              s1_go;
  logic              in_take;

  // The state register doubles as the result: it only moves when the result
  // register is free to take the new word.
  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  kscl_next u_next (
    .cur (state_r),
    .cmd (s1_cmd_r),
    .key (s1_key_r),
    .tps (tps_r),
    .nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tps_r       <= TPS_RESET;
      state_r     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) tps_r <= cfg_wr_data;
      if (s1_go) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r <= kscl_cmd_t'(in_ch.command);
      s1_key_r <= in_ch.key_code;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.count_value       = state_r.counter;
  assign out_ch.count_limit       = state_r.limit;
  assign out_ch.count_down        = state_r.down;
  assign out_ch.count_enabled     = state_r.enable;
  assign out_ch.clock_mode        = state_r.mode;
  assign out_ch.edit_field        = state_r.edit_sel;
  assign out_ch.second_digit_next = state_r.digit;
  assign out_ch.hours             = state_r.hour;
  assign out_ch.minutes           = state_r.minute;
  assign out_ch.seconds           = state_r.second;

endmodule
